FILE: hdl/mvn_pkg.sv
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared widths and controller state codes for the mean/variance normalizer.
// ----------------------------------------------------------------------------
package mvn_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MaxSamples  = 64;
  localparam int unsigned AddrWidth   = $clog2(MaxSamples);
  localparam int unsigned CountWidth  = AddrWidth + 1;
  localparam int unsigned SumWidth    = SampleWidth + AddrWidth;
  // Dividend holds |d| * (n - 1) * 2^SampleWidth; divisor holds the sum of squared deviations.
  localparam int unsigned DivWidth    = 2 * SampleWidth + AddrWidth;
  localparam int unsigned StepWidth   = $clog2(DivWidth);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_MEAN  = 9'b000000010,
    S_SQRD  = 9'b000000100,
    S_SQLD  = 9'b000001000,
    S_SQMUL = 9'b000010000,
    S_NMRD  = 9'b000100000,
    S_NMLD  = 9'b001000000,
    S_NMDIV = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

endpackage

FILE: hdl/mvn_in_if.sv
// ----------------------------------------------------------------------------
// mvn_in_if
// Sample request channel: one signed sample and its end-of-vector mark.
// ----------------------------------------------------------------------------
interface mvn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvn_pkg::SampleWidth-1:0] sample;
  logic                                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: hdl/mvn_out_if.sv
// ----------------------------------------------------------------------------
// mvn_out_if
// Result request channel: normalized element, mean and status flags.
// ----------------------------------------------------------------------------
interface mvn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvn_pkg::SampleWidth-1:0] norm_value;
  logic signed [mvn_pkg::SampleWidth-1:0] mean_value;
  logic                                variance_zero;
  logic                                last_result;

  modport source (output valid, output norm_value, output mean_value,
                  output variance_zero, output last_result, input ready);
  modport sink   (input valid, input norm_value, input mean_value,
                  input variance_zero, input last_result, output ready);
endinterface

FILE: hdl/mean_variance_normalizer_top.sv
// ----------------------------------------------------------------------------
// mean_variance_normalizer_top
// Collects a vector of samples, then emits each deviation from the mean
// divided by the sample variance, using a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | sample, last_sample
//  out_o   | out | valid / ready  | norm_value, mean_value, variance_zero, last_result
//
//  Loading accepts one sample per cycle. After the last sample the restoring
//  divider yields the mean in DivWidth (38) steps, the squaring pass reads each
//  sample into a 16-step shift-add multiplier, and each result takes a read, a
//  load, a 38-step divider pass and an emit. A zero variance gives the raw deviation.
//  Reset clears the controller, count, sum and out valid; the sample store needs none.
//  A stalled result holds the output register; the next result runs its
//  division and then waits in the emit state until the register frees.
// ----------------------------------------------------------------------------
module mean_variance_normalizer_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  mvn_in_if.sink   in_i,
  mvn_out_if.source out_o
);

  localparam int unsigned SW = mvn_pkg::SampleWidth;
  localparam int unsigned AW = mvn_pkg::AddrWidth;
  localparam int unsigned CW = mvn_pkg::CountWidth;
  localparam int unsigned UW = mvn_pkg::SumWidth;
  localparam int unsigned DW = mvn_pkg::DivWidth;
  localparam int unsigned TW = mvn_pkg::StepWidth;

  mvn_pkg::state_e state_q, state_d;

  logic [SW-1:0]        store [mvn_pkg::MaxSamples];
  logic [SW-1:0]        rd_q;

  logic [CW-1:0]        count_q, count_d;
  logic signed [UW-1:0] sum_q, sum_d;
  logic [CW-1:0]        n_q, n_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [TW-1:0]        step_q, step_d;
  logic signed [SW-1:0] mean_q, mean_d;
  logic                 neg_q, neg_d;
  logic                 vz_q, vz_d;
  logic [DW-1:0]        ssq_q, ssq_d;

  logic [2*SW-1:0]      mcand_q, mcand_d, acc_q, acc_d;
  logic [SW-1:0]        mplier_q, mplier_d;

  logic [DW-1:0]        rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [DW:0]          trial;
  logic                 trial_ge;

  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_norm_q, out_norm_d;
  logic signed [SW-1:0] out_mean_q, out_mean_d;
  logic                 out_vz_q, out_vz_d;
  logic                 out_last_q, out_last_d;

  logic                 in_go, store_room, emit_go, idx_last, big_q;
  logic signed [SW:0]   dev;
  logic [SW-1:0]        dev_mag;
  logic [AW-1:0]        nm1;
  logic [UW-1:0]        scaled;
  logic signed [UW-1:0] sum_acc;
  logic [UW-1:0]        sum_mag;
  logic signed [SW-1:0] res;

  assign in_i.ready   = (state_q == mvn_pkg::S_LOAD);
  assign in_go        = in_i.valid && in_i.ready;
  assign store_room   = (count_q < CW'(mvn_pkg::MaxSamples));
  assign sum_acc      = store_room ? (sum_q + UW'(in_i.sample)) : sum_q;
  assign sum_mag      = sum_acc[UW-1] ? UW'(-sum_acc) : UW'(sum_acc);

  assign nm1          = AW'(n_q - CW'(1));
  assign idx_last     = (idx_q == nm1);
  assign dev          = $signed({rd_q[SW-1], rd_q}) - $signed({mean_q[SW-1], mean_q});
  assign dev_mag      = dev[SW] ? SW'(-dev) : SW'(dev);
  assign scaled       = {{AW{1'b0}}, dev_mag} * {{SW{1'b0}}, nm1};

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial        = {rem_q, quo_q[DW-1]};
  assign trial_ge     = (trial >= {1'b0, dsr_q});

  assign emit_go      = !out_valid_q || out_o.ready;
  assign big_q        = |quo_q[DW-1:SW-1];

  always_comb begin
    if (vz_q) begin
      if (dev[SW] != dev[SW-1]) begin
        res = dev[SW] ? $signed({1'b1, {(SW-1){1'b0}}}) : $signed({1'b0, {(SW-1){1'b1}}});
      end else begin
        res = dev[SW-1:0];
      end
    end else if (dev[SW]) begin
      res = big_q ? $signed({1'b1, {(SW-1){1'b0}}}) : $signed(SW'(-quo_q[SW-1:0]));
    end else begin
      res = big_q ? $signed({1'b0, {(SW-1){1'b1}}}) : $signed(quo_q[SW-1:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    n_d         = n_q;
    idx_d       = idx_q;
    step_d      = step_q;
    mean_d      = mean_q;
    neg_d       = neg_q;
    vz_d        = vz_q;
    ssq_d       = ssq_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dsr_d       = dsr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_norm_d  = out_norm_q;
    out_mean_d  = out_mean_q;
    out_vz_d    = out_vz_q;
    out_last_d  = out_last_q;

    if (state_q == mvn_pkg::S_MEAN || state_q == mvn_pkg::S_NMDIV) begin
      rem_d  = trial_ge ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
      quo_d  = {quo_q[DW-2:0], trial_ge};
      step_d = step_q + TW'(1);
    end

    unique case (state_q)
      mvn_pkg::S_LOAD: begin
        if (in_go) begin
          // Drop a sample once the store is full; its last mark still counts.
          count_d = store_room ? count_q + CW'(1) : count_q;
          sum_d   = sum_acc;
          if (in_i.last_sample) begin
            n_d     = count_d;
            neg_d   = sum_acc[UW-1];
            rem_d   = '0;
            quo_d   = DW'(sum_mag);
            dsr_d   = DW'(count_d);
            step_d  = '0;
            state_d = mvn_pkg::S_MEAN;
          end
        end
      end
      mvn_pkg::S_MEAN: begin
        if (step_q == TW'(DW - 1)) begin
          mean_d  = neg_q ? SW'(-quo_d[SW-1:0]) : quo_d[SW-1:0];
          idx_d   = '0;
          ssq_d   = '0;
          state_d = mvn_pkg::S_SQRD;
        end
      end
      mvn_pkg::S_SQRD: begin
        state_d = mvn_pkg::S_SQLD;
      end
      mvn_pkg::S_SQLD: begin
        mcand_d  = (2*SW)'(dev_mag);
        mplier_d = dev_mag;
        acc_d    = '0;
        step_d   = '0;
        state_d  = mvn_pkg::S_SQMUL;
      end
      mvn_pkg::S_SQMUL: begin
        acc_d    = mplier_q[0] ? acc_q + mcand_q : acc_q;
        mcand_d  = {mcand_q[2*SW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[SW-1:1]};
        step_d   = step_q + TW'(1);
        if (step_q == TW'(SW - 1)) begin
          ssq_d = ssq_q + DW'(acc_d);
          if (idx_last) begin
            vz_d    = (ssq_d == '0);
            idx_d   = '0;
            state_d = mvn_pkg::S_NMRD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = mvn_pkg::S_SQRD;
          end
        end
      end
      mvn_pkg::S_NMRD: begin
        state_d = mvn_pkg::S_NMLD;
      end
      mvn_pkg::S_NMLD: begin
        rem_d   = '0;
        quo_d   = {scaled, {SW{1'b0}}};
        dsr_d   = ssq_q;
        step_d  = '0;
        state_d = mvn_pkg::S_NMDIV;
      end
      mvn_pkg::S_NMDIV: begin
        if (step_q == TW'(DW - 1)) begin
          state_d = mvn_pkg::S_EMIT;
        end
      end
      mvn_pkg::S_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_norm_d  = res;
          out_mean_d  = mean_q;
          out_vz_d    = vz_q;
          out_last_d  = idx_last;
          if (idx_last) begin
            count_d = '0;
            sum_d   = '0;
            state_d = mvn_pkg::S_LOAD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = mvn_pkg::S_NMRD;
          end
        end
      end
      default: state_d = mvn_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_go && store_room) begin
      store[count_q[AW-1:0]] <= in_i.sample;
    end
    rd_q <= store[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvn_pkg::S_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    idx_q      <= idx_d;
    step_q     <= step_d;
    mean_q     <= mean_d;
    neg_q      <= neg_d;
    vz_q       <= vz_d;
    ssq_q      <= ssq_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dsr_q      <= dsr_d;
    out_norm_q <= out_norm_d;
    out_mean_q <= out_mean_d;
    out_vz_q   <= out_vz_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.norm_value    = out_norm_q;
  assign out_o.mean_value    = out_mean_q;
  assign out_o.variance_zero = out_vz_q;
  assign out_o.last_result   = out_last_q;

  a_last_starts_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_go && in_i.last_sample) |=> (state_q == mvn_pkg::S_MEAN))
    else $error("last sample did not start the mean division");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(mvn_pkg::MaxSamples))
    else $error("sample count beyond store depth");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvn_pkg::S_EMIT && emit_go && idx_last)
      |=> (count_q == '0 && out_o.last_result && out_o.valid))
    else $error("final result did not clear the vector");

endmodule
